### src/gse_pkg.sv
// Shared types, ASCII codes, sentence offsets and weight functions for the
// GPS sentence field extractor. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gse_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_P    = 2'd1,
        KIND_POS  = 2'd2,
        KIND_HEAD = 2'd3
    } sentence_kind_t;

    localparam logic REPORT_POSITION = 1'b0;
    localparam logic REPORT_HEADING  = 1'b1;

    localparam logic [7:0] ASCII_DOLLAR = 8'h24;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] ASCII_P      = 8'h50;
    localparam logic [7:0] ASCII_G      = 8'h47;
    localparam logic [7:0] ASCII_V      = 8'h56;
    localparam logic [7:0] ASCII_DOT    = 8'h2E;

    localparam logic [5:0] OFFSET_IDLE     = 6'd63;
    localparam logic [5:0] OFF_TALKER      = 6'd2;
    localparam logic [5:0] OFF_TYPE        = 6'd3;
    localparam logic [5:0] OFF_POS_REPORT  = 6'd46;
    localparam logic [5:0] OFF_HEAD_DIG0   = 6'd7;
    localparam logic [5:0] OFF_HEAD_DIG1   = 6'd8;
    localparam logic [5:0] OFF_HEAD_SEP    = 6'd9;
    localparam logic [5:0] OFF_HEAD_SHORT  = 6'd10;
    localparam logic [5:0] OFF_HEAD_LONG   = 6'd11;

    localparam int LAT_W  = 40;
    localparam int LON_W  = 43;
    localparam int HEAD_W = 14;

    typedef struct packed {
        logic                report_kind;
        logic [LAT_W-1:0]    latitude_value;
        logic [LON_W-1:0]    longitude_value;
        logic [HEAD_W-1:0]   heading_tenths;
        logic                fields_valid;
    } gse_result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] b);
        return is_digit(b) ? b[3:0] : 4'd0;
    endfunction

    function automatic logic is_lat_offset(input logic [5:0] o);
        return ((o >= 6'd17) && (o <= 6'd20)) || ((o >= 6'd22) && (o <= 6'd29));
    endfunction

    function automatic logic is_lon_offset(input logic [5:0] o);
        return ((o >= 6'd33) && (o <= 6'd37)) || ((o >= 6'd39) && (o <= 6'd46));
    endfunction

    // Weight of one digit in units of 1e-8 arc-minute; degrees carry a factor of 60.
    function automatic logic [LON_W-1:0] digit_weight(input logic [5:0] o);
        logic [LON_W-1:0] w;
        w = '0;
        unique case (o)
            6'd17: w = 43'd60000000000;
            6'd18: w = 43'd6000000000;
            6'd19: w = 43'd1000000000;
            6'd20: w = 43'd100000000;
            6'd22: w = 43'd10000000;
            6'd23: w = 43'd1000000;
            6'd24: w = 43'd100000;
            6'd25: w = 43'd10000;
            6'd26: w = 43'd1000;
            6'd27: w = 43'd100;
            6'd28: w = 43'd10;
            6'd29: w = 43'd1;
            6'd33: w = 43'd600000000000;
            6'd34: w = 43'd60000000000;
            6'd35: w = 43'd6000000000;
            6'd36: w = 43'd1000000000;
            6'd37: w = 43'd100000000;
            6'd39: w = 43'd10000000;
            6'd40: w = 43'd1000000;
            6'd41: w = 43'd100000;
            6'd42: w = 43'd10000;
            6'd43: w = 43'd1000;
            6'd44: w = 43'd100;
            6'd45: w = 43'd10;
            6'd46: w = 43'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### src/gps_sentence_field_extractor_unit.sv
// Top level of the GPS sentence field extractor.
// Instantiates gse_in_reg, gse_parser and gse_out_reg; uses gse_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one received byte per cycle and reports position sentences
// (talker type 'P','G') on their last longitude digit and heading sentences
// ('P','V') on their last heading digit. A byte passes through an input
// register and the parser, and its report, if any, is loaded into the result
// register as the byte leaves the input register; a new byte is taken in every
// cycle unless a finished report is held by the downstream side. The rate is
// set by the parser's state update, which is made for each byte: the offset
// counter and a digit-times-weight add into the coordinate accumulators.

module gps_sentence_field_extractor_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             report_kind,
    output logic [39:0]      latitude_value,
    output logic [42:0]      longitude_value,
    output logic [13:0]      heading_tenths,
    output logic             fields_valid
);

    import gse_pkg::*;

    logic        advance;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        step;
    logic        res_valid;
    gse_result_t res;
    gse_result_t out_data;

    assign step = byte_valid && advance;

    gse_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    gse_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_data   (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    gse_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign report_kind     = out_data.report_kind;
    assign latitude_value  = out_data.latitude_value;
    assign longitude_value = out_data.longitude_value;
    assign heading_tenths  = out_data.heading_tenths;
    assign fields_valid    = out_data.fields_valid;

`ifndef SYNTHESIS
    a_report_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |=> out_valid)
        else $error("parsed report did not reach the result register");

    a_heading_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == REPORT_HEADING |->
            latitude_value == '0 && longitude_value == '0)
        else $error("heading report carries coordinates");

    a_position_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_kind == REPORT_POSITION |-> heading_tenths == '0)
        else $error("position report carries a heading");

    a_no_step_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid |-> !(step && res_valid))
        else $error("report produced without a byte");
`endif

endmodule

`default_nettype wire

### src/gse_in_reg.sv
// Input register for received bytes, with valid/ready flow control.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module gse_in_reg
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign in_ready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

### src/gse_parser.sv
// Sentence parser: offset counter, sentence kind, coordinate accumulators and
// heading digits, producing at most one result per byte. Uses gse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gse_parser
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         rx_data,
    output logic                    res_valid,
    output gse_pkg::gse_result_t    res
);

    import gse_pkg::*;

    logic [5:0]        offset_reg, offset_next;
    sentence_kind_t    kind_reg, kind_next;
    logic [LAT_W-1:0]  lat_reg, lat_next;
    logic [LON_W-1:0]  lon_reg, lon_next;
    logic [3:0]        h0_reg, h0_next;
    logic [3:0]        h1_reg, h1_next;
    logic [3:0]        h2_reg, h2_next;
    logic              dot_reg, dot_next;
    logic              bad_reg, bad_next;

    logic [5:0]        offs;
    logic [3:0]        dig;
    logic              not_dig;
    logic [LON_W-1:0]  prod;
    logic [HEAD_W-1:0] head_short;
    logic [HEAD_W-1:0] head_long;

    assign offs    = offset_reg + 6'd1;
    assign dig     = digit_value(rx_data);
    assign not_dig = !is_digit(rx_data);
    assign prod    = LON_W'(dig) * digit_weight(offs);

    assign head_short = HEAD_W'(h0_reg) * HEAD_W'(100) + HEAD_W'(h1_reg) * HEAD_W'(10)
                      + HEAD_W'(dig);
    assign head_long  = HEAD_W'(h0_reg) * HEAD_W'(1000) + HEAD_W'(h1_reg) * HEAD_W'(100)
                      + HEAD_W'(h2_reg) * HEAD_W'(10) + HEAD_W'(dig);

    always_comb
    begin
        offset_next = offset_reg;
        kind_next   = kind_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        h0_next     = h0_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        dot_next    = dot_reg;
        bad_next    = bad_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (step)
        begin
            if (rx_data == ASCII_DOLLAR)
            begin
                offset_next = '0;
                kind_next   = KIND_NONE;
                lat_next    = '0;
                lon_next    = '0;
                h0_next     = '0;
                h1_next     = '0;
                h2_next     = '0;
                dot_next    = 1'b0;
                bad_next    = 1'b0;
            end
            else if (offset_reg != OFFSET_IDLE)
            begin
                offset_next = offs;
                if (offs == OFF_TALKER)
                begin
                    kind_next = (rx_data == ASCII_P) ? KIND_P : KIND_NONE;
                end
                else if (offs == OFF_TYPE)
                begin
                    if (kind_reg == KIND_P && rx_data == ASCII_G)
                    begin
                        kind_next = KIND_POS;
                    end
                    else if (kind_reg == KIND_P && rx_data == ASCII_V)
                    begin
                        kind_next = KIND_HEAD;
                    end
                    else
                    begin
                        kind_next = KIND_NONE;
                    end
                end
                else if (kind_reg == KIND_POS)
                begin
                    if (is_lat_offset(offs))
                    begin
                        lat_next = lat_reg + prod[LAT_W-1:0];
                        bad_next = bad_reg || not_dig;
                    end
                    else if (is_lon_offset(offs))
                    begin
                        lon_next = lon_reg + prod;
                        bad_next = bad_reg || not_dig;
                        if (offs == OFF_POS_REPORT)
                        begin
                            res_valid           = 1'b1;
                            res.report_kind     = REPORT_POSITION;
                            res.latitude_value  = lat_reg;
                            res.longitude_value = lon_next;
                            res.fields_valid    = !bad_next;
                        end
                    end
                end
                else if (kind_reg == KIND_HEAD)
                begin
                    if (offs == OFF_HEAD_DIG0)
                    begin
                        h0_next  = dig;
                        bad_next = bad_reg || not_dig;
                    end
                    else if (offs == OFF_HEAD_DIG1)
                    begin
                        h1_next  = dig;
                        bad_next = bad_reg || not_dig;
                    end
                    else if (offs == OFF_HEAD_SEP)
                    begin
                        if (rx_data == ASCII_DOT)
                        begin
                            dot_next = 1'b1;
                            h2_next  = '0;
                        end
                        else
                        begin
                            dot_next = 1'b0;
                            h2_next  = dig;
                            bad_next = bad_reg || not_dig;
                        end
                    end
                    else if (offs == OFF_HEAD_SHORT && dot_reg)
                    begin
                        bad_next           = bad_reg || not_dig;
                        res_valid          = 1'b1;
                        res.report_kind    = REPORT_HEADING;
                        res.heading_tenths = head_short;
                        res.fields_valid   = !bad_next;
                    end
                    else if (offs == OFF_HEAD_LONG && !dot_reg)
                    begin
                        bad_next           = bad_reg || not_dig;
                        res_valid          = 1'b1;
                        res.report_kind    = REPORT_HEADING;
                        res.heading_tenths = head_long;
                        res.fields_valid   = !bad_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_IDLE;
            kind_reg   <= KIND_NONE;
            lat_reg    <= '0;
            lon_reg    <= '0;
            h0_reg     <= '0;
            h1_reg     <= '0;
            h2_reg     <= '0;
            dot_reg    <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            kind_reg   <= kind_next;
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
            h0_reg     <= h0_next;
            h1_reg     <= h1_next;
            h2_reg     <= h2_next;
            dot_reg    <= dot_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

`default_nettype wire

### src/gse_out_reg.sv
// Result register holding one report until the downstream transfer completes.
// Uses gse_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module gse_out_reg
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire gse_pkg::gse_result_t   res,
    output logic                        advance,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output gse_pkg::gse_result_t        out_data
);

    import gse_pkg::*;

    logic        valid_reg;
    gse_result_t data_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load)
        begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for gps_sentence_field_extractor_unit: feeds byte streams
// of position, heading, unknown and broken sentences and checks every report.
// Depends on gse_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;

    import gse_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int FULL = 99;

    typedef enum int {
        FORM_POSITION,
        FORM_HEAD_DOT,
        FORM_HEAD_LONG,
        FORM_OTHER
    } sentence_form_t;

    typedef enum int {
        DIGITS_RANDOM,
        DIGITS_ZERO,
        DIGITS_NINE
    } digit_mode_t;

    typedef struct {
        logic [7:0] value;
        bit         drain_first;
    } rx_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] rx_byte = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic report_kind;
    logic [39:0] latitude_value;
    logic [42:0] longitude_value;
    logic [13:0] heading_tenths;
    logic fields_valid;

    rx_item_t byte_backlog[$];
    gse_result_t pending_reports[$];

    int unsigned bytes_planned = 0;
    int unsigned reports_planned = 0;
    int unsigned bytes_offered = 0;
    int unsigned bytes_taken = 0;
    int unsigned reports_seen = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit hold_done = 1'b0;
    bit drain_next = 1'b0;

    // Model of the block's parser state.
    logic [5:0] cur_offset = OFFSET_IDLE;
    sentence_kind_t parse_kind = KIND_NONE;
    logic [6:0] lat_deg = '0;
    logic [33:0] lat_min = '0;
    logic [9:0] lon_deg = '0;
    logic [33:0] lon_min = '0;
    logic [3:0] head_digit[5] = '{default: '0};
    logic dot_nine = 1'b0;
    logic saw_bad = 1'b0;

    gps_sentence_field_extractor_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .report_kind     (report_kind),
        .latitude_value  (latitude_value),
        .longitude_value (longitude_value),
        .heading_tenths  (heading_tenths),
        .fields_valid    (fields_valid)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned ten_to(input int n);
        longint unsigned v;
        v = 1;
        repeat (n) v = v * 10;
        return v;
    endfunction

    function automatic logic [3:0] ascii_digit(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return 4'(b - 8'h30);
        end
        saw_bad = 1'b1;
        return 4'd0;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        gse_result_t r;
        int unsigned h;
        int o;
        bit emit;
        emit = 1'b0;
        r = '0;
        if (b == ASCII_DOLLAR)
        begin
            cur_offset = '0;
            parse_kind = KIND_NONE;
            lat_deg = '0;
            lat_min = '0;
            lon_deg = '0;
            lon_min = '0;
            foreach (head_digit[i]) head_digit[i] = '0;
            dot_nine = 1'b0;
            saw_bad = 1'b0;
        end
        else if (cur_offset != OFFSET_IDLE)
        begin
            cur_offset = cur_offset + 6'd1;
            o = int'(cur_offset);
            if (cur_offset == OFF_TALKER)
            begin
                parse_kind = (b == ASCII_P) ? KIND_P : KIND_NONE;
            end
            else if (cur_offset == OFF_TYPE)
            begin
                if (parse_kind == KIND_P && b == ASCII_G)
                    parse_kind = KIND_POS;
                else if (parse_kind == KIND_P && b == ASCII_V)
                    parse_kind = KIND_HEAD;
                else
                    parse_kind = KIND_NONE;
            end
            else if (parse_kind == KIND_POS)
            begin
                if (o == 17 || o == 18)
                    lat_deg = 7'(lat_deg * 10 + ascii_digit(b));
                else if (o == 19 || o == 20)
                    lat_min = 34'(lat_min + ascii_digit(b) * ten_to(28 - o));
                else if (o >= 22 && o <= 29)
                    lat_min = 34'(lat_min + ascii_digit(b) * ten_to(29 - o));
                else if (o >= 33 && o <= 35)
                    lon_deg = 10'(lon_deg * 10 + ascii_digit(b));
                else if (o == 36 || o == 37)
                    lon_min = 34'(lon_min + ascii_digit(b) * ten_to(45 - o));
                else if (o >= 39 && o <= 46)
                begin
                    lon_min = 34'(lon_min + ascii_digit(b) * ten_to(46 - o));
                    if (cur_offset == OFF_POS_REPORT)
                    begin
                        emit = 1'b1;
                        r.report_kind = REPORT_POSITION;
                        r.latitude_value = 40'(64'(lat_deg) * 64'd6000000000 + lat_min);
                        r.longitude_value = 43'(64'(lon_deg) * 64'd6000000000 + lon_min);
                    end
                end
            end
            else if (parse_kind == KIND_HEAD)
            begin
                if (cur_offset == OFF_HEAD_DIG0 || cur_offset == OFF_HEAD_DIG1)
                begin
                    head_digit[o - 7] = ascii_digit(b);
                end
                else if (cur_offset == OFF_HEAD_SEP)
                begin
                    if (b == ASCII_DOT)
                    begin
                        dot_nine = 1'b1;
                        head_digit[2] = '0;
                    end
                    else
                    begin
                        dot_nine = 1'b0;
                        head_digit[2] = ascii_digit(b);
                    end
                end
                else if (cur_offset == OFF_HEAD_SHORT && dot_nine)
                begin
                    head_digit[3] = ascii_digit(b);
                    h = head_digit[0] * 100 + head_digit[1] * 10 + head_digit[3];
                    emit = 1'b1;
                end
                else if (cur_offset == OFF_HEAD_LONG && !dot_nine)
                begin
                    head_digit[4] = ascii_digit(b);
                    h = head_digit[0] * 1000 + head_digit[1] * 100
                        + head_digit[2] * 10 + head_digit[4];
                    emit = 1'b1;
                end
                if (emit)
                begin
                    r.report_kind = REPORT_HEADING;
                    r.heading_tenths = 14'(h);
                end
            end
        end
        if (emit)
        begin
            r.fields_valid = !saw_bad;
            pending_reports = {pending_reports, r};
        end
    endtask

    function automatic logic [7:0] any_filler();
        logic [7:0] v;
        v = ASCII_DOLLAR;
        while (v == ASCII_DOLLAR) v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] v;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return 8'h2F;
        if (pick < 4)
            return 8'h3A;
        v = ASCII_ZERO;
        while ((v >= ASCII_ZERO && v <= ASCII_NINE) || v == ASCII_DOLLAR || v == ASCII_DOT)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic queue_byte(input logic [7:0] v);
        rx_item_t it;
        it.value = v;
        it.drain_first = drain_next;
        drain_next = 1'b0;
        byte_backlog = {byte_backlog, it};
        bytes_planned++;
    endtask

    task automatic queue_sentence(input sentence_form_t form, input digit_mode_t mode,
                                  input int bad_count, input int keep, input int tail_len);
        logic [7:0] s[47];
        int digit_pos[$];
        int len;
        int d;
        foreach (s[i]) s[i] = any_filler();
        s[0] = ASCII_DOLLAR;
        s[1] = ASCII_G;
        s[2] = ASCII_P;
        len = 47;
        case (form)
            FORM_POSITION:
            begin
                s[3] = ASCII_G;
                for (int p = 17; p <= 46; p++)
                    if (p != 21 && (p < 30 || p > 32) && p != 38)
                        digit_pos = {digit_pos, p};
            end
            FORM_HEAD_DOT:
            begin
                len = 11;
                s[3] = ASCII_V;
                s[9] = ASCII_DOT;
                digit_pos = '{7, 8, 10};
            end
            FORM_HEAD_LONG:
            begin
                len = 12;
                s[3] = ASCII_V;
                digit_pos = '{7, 8, 9, 11};
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    while (s[3] == ASCII_G || s[3] == ASCII_V) s[3] = any_filler();
                end
                else
                begin
                    while (s[2] == ASCII_P) s[2] = any_filler();
                    s[3] = $urandom_range(0, 1) ? ASCII_G : ASCII_V;
                end
            end
        endcase
        foreach (digit_pos[i])
        begin
            d = (mode == DIGITS_ZERO) ? 0 : (mode == DIGITS_NINE) ? 9 : $urandom_range(0, 9);
            s[digit_pos[i]] = 8'(ASCII_ZERO + d);
        end
        if (digit_pos.size() != 0)
            repeat (bad_count) s[digit_pos[$urandom_range(0, digit_pos.size() - 1)]] = non_digit();
        for (int i = 0; i < len && i < keep; i++) queue_byte(s[i]);
        repeat (tail_len) queue_byte(any_filler());
        if (keep >= len && form != FORM_OTHER)
            reports_planned++;
    endtask

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        gse_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
        begin
            parse_byte(rx_byte);
            bytes_taken++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("report transfer with none pending: kind %0d", report_kind);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("report_kind", 64'(want.report_kind), 64'(report_kind));
                check_field("latitude_value", 64'(want.latitude_value), 64'(latitude_value));
                check_field("longitude_value", 64'(want.longitude_value),
                            64'(longitude_value));
                check_field("heading_tenths", 64'(want.heading_tenths), 64'(heading_tenths));
                check_field("fields_valid", 64'(want.fields_valid), 64'(fields_valid));
            end
        end
    end

    always @(negedge clk)
    begin : driver
        rx_item_t it;
        if (rst_n && bytes_taken == bytes_offered)
        begin
            if (byte_backlog.size() != 0
                && !(byte_backlog[0].drain_first && pending_reports.size() != 0)
                && !((bytes_offered < 200 || bytes_offered >= 450)
                     && $urandom_range(0, 99) < 10))
            begin
                it = byte_backlog.pop_front();
                rx_byte <= it.value;
                in_valid <= 1'b1;
                bytes_offered++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && bytes_taken >= 500)
        begin
            hold_done <= 1'b1;
            hold_left <= 200;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !((reports_seen < 10 || reports_seen >= 20)
                           && $urandom_range(0, 99) < 10);
        end
    end

    initial
    begin
        digit_mode_t mode;
        int pick;
        int bad;
        int tail;
        bit mid_drain_set;
        mid_drain_set = 1'b0;

        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(ASCII_P);
        queue_byte(ASCII_G);
        queue_sentence(FORM_POSITION, DIGITS_ZERO, 0, FULL, 2);
        queue_sentence(FORM_POSITION, DIGITS_NINE, 0, FULL, 5);
        queue_sentence(FORM_POSITION, DIGITS_RANDOM, 0, FULL, 0);
        queue_sentence(FORM_POSITION, DIGITS_RANDOM, 3, FULL, 3);
        queue_sentence(FORM_HEAD_DOT, DIGITS_NINE, 0, FULL, 4);
        queue_sentence(FORM_HEAD_DOT, DIGITS_ZERO, 0, FULL, 0);
        queue_sentence(FORM_HEAD_DOT, DIGITS_RANDOM, 1, FULL, 2);
        queue_sentence(FORM_HEAD_LONG, DIGITS_NINE, 0, FULL, 3);
        queue_sentence(FORM_HEAD_LONG, DIGITS_ZERO, 0, FULL, 0);
        queue_sentence(FORM_HEAD_LONG, DIGITS_RANDOM, 2, FULL, 1);
        queue_sentence(FORM_POSITION, DIGITS_RANDOM, 0, 30, 0);
        queue_sentence(FORM_HEAD_LONG, DIGITS_RANDOM, 0, 9, 0);
        queue_sentence(FORM_OTHER, DIGITS_RANDOM, 0, FULL, 0);
        queue_sentence(FORM_OTHER, DIGITS_NINE, 0, FULL, 0);
        queue_sentence(FORM_POSITION, DIGITS_RANDOM, 0, FULL, 80);
        queue_byte(ASCII_DOLLAR);
        queue_byte(ASCII_DOLLAR);
        queue_sentence(FORM_HEAD_DOT, DIGITS_RANDOM, 0, FULL, 0);

        drain_next = 1'b1;
        while (bytes_planned < 1150 || reports_planned < 40)
        begin
            pick = $urandom_range(0, 99);
            mode = DIGITS_RANDOM;
            if ($urandom_range(0, 19) == 0)
                mode = $urandom_range(0, 1) ? DIGITS_ZERO : DIGITS_NINE;
            bad = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
            tail = ($urandom_range(0, 99) < 4) ? $urandom_range(20, 70) : $urandom_range(0, 12);
            if (!mid_drain_set && bytes_planned > 700)
            begin
                drain_next = 1'b1;
                mid_drain_set = 1'b1;
            end
            if (pick < 40)
                queue_sentence(FORM_POSITION, mode, bad, FULL, tail);
            else if (pick < 58)
                queue_sentence(FORM_HEAD_DOT, mode, bad, FULL, tail);
            else if (pick < 76)
                queue_sentence(FORM_HEAD_LONG, mode, bad, FULL, tail);
            else if (pick < 86)
                queue_sentence(FORM_OTHER, mode, bad, FULL, tail);
            else if (pick < 94)
            begin
                case ($urandom_range(0, 2))
                    0: queue_sentence(FORM_POSITION, mode, bad, $urandom_range(1, 46), 0);
                    1: queue_sentence(FORM_HEAD_DOT, mode, bad, $urandom_range(1, 10), 0);
                    default: queue_sentence(FORM_HEAD_LONG, mode, bad, $urandom_range(1, 11), 0);
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 8)) queue_byte(any_filler());
            end
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        while (bytes_taken != bytes_planned || pending_reports.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (error_count == 0 && pending_reports.size() == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

### gps_sentence_field_extractor_unit.f
src/gse_pkg.sv
src/gse_in_reg.sv
src/gse_parser.sv
src/gse_out_reg.sv
src/gps_sentence_field_extractor_unit.sv
tb/tb.sv
